// ===== rtl/core/xcfr_pkg.sv =====
package xcfr_pkg;

  // Frame geometry
  localparam int MAX_PAYLOAD = 32;
  localparam int STORE_DEPTH = MAX_PAYLOAD + 4;
  localparam int POS_W       = $clog2(STORE_DEPTH + 2);
  localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam logic [7:0] END_BYTE    = 8'h0a;
  localparam logic [7:0] HEADER_INIT = 8'hAA;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_HEADER  = 1'b0,
    CFG_DELIVER = 1'b1
  } cfg_idx_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_HUNT,
    ST_CMD,
    ST_LEN,
    ST_DATA,
    ST_CHECK,
    ST_END,
    ST_READ,
    ST_SHOW
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic st_hdr;   // write header at entry 0, position to 1
    logic st_put;   // write at position, advance
    logic ld_len;   // latch payload length
    logic clr_xor;  // clear running xor
    logic xor_en;   // fold byte into running xor
    logic pos_inc;  // advance position only
    logic rd_clr;   // readout index to zero
    logic rd_req;   // read store at readout index
    logic rd_next;  // advance readout index
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hdr_match;
    logic len_ok;
    logic data_done;
    logic len_zero;
    logic end_match;
    logic pos_at_end;
    logic deliver;
    logic rd_last;
  } sts_t;

endpackage

// ===== rtl/core/xcfr_dp.sv =====
module xcfr_dp
  import xcfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic [7:0]  rx_byte,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic [7:0]  frame_byte,
  output logic [5:0]  byte_index,
  output logic        last_byte
);

  logic [7:0]       header_r;
  logic             deliver_r;
  logic [POS_W-1:0] pos_r;
  logic [LEN_W-1:0] len_r;
  logic [7:0]       xor_r;
  logic [ADDR_W-1:0] k_r;
  logic [7:0]       rd_data_r;
  logic [7:0]       store_mem [0:STORE_DEPTH-1];
  logic [ADDR_W-1:0] wr_addr;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r  <= HEADER_INIT;
      deliver_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_HEADER:  header_r  <= cfg_wdata;
        CFG_DELIVER: deliver_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Frame store, one write and one registered read port
  assign wr_addr = cmd.st_hdr ? '0 : pos_r[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.st_hdr || cmd.st_put) begin
      store_mem[wr_addr] <= rx_byte;
    end
    if (cmd.rd_req) begin
      rd_data_r <= store_mem[k_r];
    end
  end

  // Position, length, running xor, readout index
  always_ff @(posedge clk) begin
    if (cmd.st_hdr) begin
      pos_r <= POS_W'(1);
    end else if (cmd.st_put || cmd.pos_inc) begin
      pos_r <= pos_r + POS_W'(1);
    end
    if (cmd.ld_len) begin
      len_r <= rx_byte[LEN_W-1:0];
    end
    if (cmd.clr_xor) begin
      xor_r <= 8'h00;
    end else if (cmd.xor_en) begin
      xor_r <= xor_r ^ rx_byte;
    end
    if (cmd.rd_clr) begin
      k_r <= '0;
    end else if (cmd.rd_next) begin
      k_r <= k_r + ADDR_W'(1);
    end
  end

  // Status
  always_comb begin
    sts.hdr_match  = (rx_byte == header_r);
    sts.len_ok     = (rx_byte <= 8'(MAX_PAYLOAD));
    sts.data_done  = ({1'b0, pos_r} + (POS_W+1)'(1)) >= ((POS_W+1)'(len_r) + (POS_W+1)'(3));
    sts.len_zero   = (len_r == '0);
    sts.end_match  = (rx_byte == END_BYTE);
    sts.pos_at_end = ({1'b0, pos_r} == ((POS_W+1)'(len_r) + (POS_W+1)'(4)));
    sts.deliver    = deliver_r;
    sts.rd_last    = ((POS_W+1)'(k_r) == ((POS_W+1)'(len_r) + (POS_W+1)'(3)));
  end

  // Output word: entry 0 carries the computed xor
  assign frame_byte = (k_r == '0) ? xor_r : rd_data_r;
  assign byte_index = 6'(k_r);
  assign last_byte  = sts.rd_last;

  a_rd_clr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_clr |=> k_r == '0)
    else $error("readout index not cleared");
  a_xor_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.xor_en |-> len_r <= LEN_W'(MAX_PAYLOAD))
    else $error("payload folded with oversize length");
  a_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.st_hdr && cmd.st_put))
    else $error("two store writes in one cycle");

endmodule

// ===== rtl/core/xcfr_ctrl.sv =====
module xcfr_ctrl
  import xcfr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   rx_go, tx_go;

  assign rx_go = in_valid && in_ready;
  assign tx_go = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_HUNT:  if (rx_go && sts.hdr_match) state_nxt = ST_CMD;
      ST_CMD:   if (rx_go) state_nxt = ST_LEN;
      ST_LEN:   if (rx_go) state_nxt = sts.len_ok ? ST_DATA : ST_HUNT;
      ST_DATA:  if (rx_go && sts.data_done) state_nxt = ST_CHECK;
      ST_CHECK: if (rx_go) state_nxt = sts.len_zero ? ST_HUNT : ST_END;
      ST_END: begin
        if (rx_go) begin
          if (sts.end_match) begin
            state_nxt = sts.deliver ? ST_READ : ST_HUNT;
          end else if (!sts.pos_at_end) begin
            state_nxt = ST_HUNT;
          end
        end
      end
      ST_READ:  state_nxt = ST_SHOW;
      ST_SHOW:  if (tx_go) state_nxt = sts.rd_last ? ST_HUNT : ST_READ;
      default:  state_nxt = ST_HUNT;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_HUNT: begin
        in_ready   = 1'b1;
        cmd.st_hdr = rx_go && sts.hdr_match;
      end
      ST_CMD: begin
        in_ready   = 1'b1;
        cmd.st_put = rx_go;
      end
      ST_LEN: begin
        in_ready    = 1'b1;
        cmd.st_put  = rx_go;
        cmd.ld_len  = rx_go && sts.len_ok;
        cmd.clr_xor = rx_go && sts.len_ok;
      end
      ST_DATA: begin
        in_ready   = 1'b1;
        cmd.st_put = rx_go;
        cmd.xor_en = rx_go;
      end
      ST_CHECK: begin
        in_ready   = 1'b1;
        cmd.st_put = rx_go && !sts.len_zero;
      end
      ST_END: begin
        in_ready    = 1'b1;
        cmd.rd_clr  = rx_go && sts.end_match && sts.deliver;
        cmd.pos_inc = rx_go && !sts.end_match && sts.pos_at_end;
      end
      ST_READ: begin
        cmd.rd_req = 1'b1;
      end
      ST_SHOW: begin
        out_valid   = 1'b1;
        cmd.rd_next = tx_go && !sts.rd_last;
      end
      default: ;
    endcase
  end

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output open together");
  a_next_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (tx_go && !sts.rd_last) |=> state_r == ST_READ)
    else $error("readout did not continue");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    (tx_go && sts.rd_last) |=> state_r == ST_HUNT)
    else $error("readout did not finish");

endmodule

// ===== rtl/core/xor_checked_frame_receiver.sv =====
// Byte-serial frame receiver. Takes one received byte per cycle on in_* while
// hunting for and collecting a frame (header, command, length, payload, check,
// end byte 0x0a in the first or second slot after the check). A completed frame
// is read out of the internal 36-entry store on out_*, one word per byte with
// byte 0 replaced by the xor of the payload; each word is read from the store
// and then presented, so a frame of length L streams out as L+4 words, paced
// by out_tready, and no input byte is taken during that time. Oversize or
// zero lengths and a bad end byte drop the frame silently; the received check
// byte is passed through but never compared. cfg index 0 sets the header byte,
// index 1 enables delivery.
module xor_checked_frame_receiver
  import xcfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] frame_byte, [13:8] byte_index, [15:14] zero
  output logic        out_tlast   // last_byte
);

  cmd_t       cmd;
  sts_t       sts;
  logic [7:0] frame_byte;
  logic [5:0] byte_index;

  xcfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  xcfr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .rx_byte    (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .frame_byte (frame_byte),
    .byte_index (byte_index),
    .last_byte  (out_tlast)
  );

  assign out_tdata = {2'b00, byte_index, frame_byte};

endmodule
